// File: rtl/core/mme_pkg.sv
`default_nettype none

package mme_pkg;

  // Largest matrix edge supported by default.
  localparam int DIM_DEFAULT = 8;

  // Configuration port geometry: four 32-bit registers at byte addresses 4*i.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_ROWS_FIRST  = 2'd0;
  localparam logic [1:0] REG_COLS_FIRST  = 2'd1;
  localparam logic [1:0] REG_ROWS_SECOND = 2'd2;
  localparam logic [1:0] REG_COLS_SECOND = 2'd3;

  typedef enum logic [1:0] {
    OP_WR_FIRST  = 2'd0,
    OP_WR_SECOND = 2'd1,
    OP_COMPUTE   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_ERR
  } seq_state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] product_value;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic               last_flag;
    logic               error_flag;
  } out_word_t;

  typedef struct packed {
    logic [3:0] rows_first;
    logic [3:0] cols_first;
    logic [3:0] rows_second;
    logic [3:0] cols_second;
  } cfg_dims_t;

  // Control carried alongside each multiply-accumulate step.
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       lastk;
    logic       last;
    logic       err;
    logic [2:0] row;
    logic [2:0] col;
  } mac_tag_t;

endpackage

`default_nettype wire

// File: rtl/core/mme_ram.sv
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/mme_seq.sv
`default_nettype none

module mme_seq #(
  parameter int DIM = mme_pkg::DIM_DEFAULT,
  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1,
  localparam int AW = (DIM > 1) ? $clog2(DIM * DIM) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mme_pkg::cfg_dims_t dims,
  input  wire logic              start,
  input  wire logic              adv,
  output logic                   idle,
  output logic                   re,
  output logic [AW-1:0]          addr_a,
  output logic [AW-1:0]          addr_b,
  output mme_pkg::mac_tag_t      tag
);

  function automatic logic [3:0] clamp_dim(input logic [3:0] v);
    logic [3:0] r;
    begin
      if (v == 4'd0) begin
        r = 4'd1;
      end else if (32'(v) > DIM) begin
        r = 4'(DIM);
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

  mme_pkg::seq_state_t state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [3:0] m_c, inner_c, inner2_c, n_c;
  logic at_k_end, at_j_end, at_i_end;

  assign m_c      = clamp_dim(dims.rows_first);
  assign inner_c  = clamp_dim(dims.cols_first);
  assign inner2_c = clamp_dim(dims.rows_second);
  assign n_c      = clamp_dim(dims.cols_second);

  assign at_k_end = (4'(k_r) == inner_c - 4'd1);
  assign at_j_end = (4'(j_r) == n_c - 4'd1);
  assign at_i_end = (4'(i_r) == m_c - 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::SEQ_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      mme_pkg::SEQ_IDLE: begin
        if (start) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = (inner_c != inner2_c) ? mme_pkg::SEQ_ERR : mme_pkg::SEQ_RUN;
        end
      end
      mme_pkg::SEQ_ERR: begin
        if (adv) begin
          state_nxt = mme_pkg::SEQ_IDLE;
        end
      end
      mme_pkg::SEQ_RUN: begin
        if (adv) begin
          if (at_k_end) begin
            k_nxt = '0;
            if (at_j_end) begin
              j_nxt = '0;
              if (at_i_end) begin
                state_nxt = mme_pkg::SEQ_IDLE;
              end else begin
                i_nxt = i_r + IW'(1);
              end
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end else begin
            k_nxt = k_r + IW'(1);
          end
        end
      end
      default: state_nxt = mme_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    tag.valid = (state_r != mme_pkg::SEQ_IDLE);
    tag.err   = (state_r == mme_pkg::SEQ_ERR);
    tag.first = tag.err || (k_r == '0);
    tag.lastk = tag.err || at_k_end;
    tag.last  = tag.err || (at_i_end && at_j_end);
    tag.row   = 3'(i_r);
    tag.col   = 3'(j_r);
  end

  assign idle   = (state_r == mme_pkg::SEQ_IDLE);
  assign re     = adv && tag.valid;
  assign addr_a = AW'(32'(i_r) * DIM + 32'(k_r));
  assign addr_b = AW'(32'(k_r) * DIM + 32'(j_r));

endmodule

`default_nettype wire

// File: rtl/core/mme_mac.sv
`default_nettype none

module mme_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire mme_pkg::mac_tag_t  tag_in,
  input  wire logic signed [15:0] a_data,
  input  wire logic signed [15:0] b_data,
  output logic                    res_valid,
  output mme_pkg::out_word_t      res
);

  mme_pkg::mac_tag_t t1_r, t2_r;
  logic signed [31:0] mult;
  logic [31:0] prod_r;
  logic [31:0] acc_r;
  logic [31:0] sum;

  // Stage one lines up with the store read data; stage two with the product.
  assign mult = a_data * b_data;
  assign sum  = t2_r.first ? prod_r : acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid <= 1'b0;
      t2_r.valid <= 1'b0;
    end else if (adv) begin
      t1_r.valid <= tag_in.valid;
      t2_r.valid <= t1_r.valid;
    end
    if (adv) begin
      t1_r.first <= tag_in.first;
      t1_r.lastk <= tag_in.lastk;
      t1_r.last  <= tag_in.last;
      t1_r.err   <= tag_in.err;
      t1_r.row   <= tag_in.row;
      t1_r.col   <= tag_in.col;
      t2_r.first <= t1_r.first;
      t2_r.lastk <= t1_r.lastk;
      t2_r.last  <= t1_r.last;
      t2_r.err   <= t1_r.err;
      t2_r.row   <= t1_r.row;
      t2_r.col   <= t1_r.col;
      prod_r     <= t1_r.err ? 32'd0 : mult;
      if (t2_r.valid) begin
        acc_r <= sum;
      end
    end
  end

  assign res_valid         = t2_r.valid && t2_r.lastk;
  assign res.product_value = sum;
  assign res.out_row       = t2_r.row;
  assign res.out_col       = t2_r.col;
  assign res.last_flag     = t2_r.last;
  assign res.error_flag    = t2_r.err;

endmodule

`default_nettype wire

// File: rtl/core/matrix_multiply_engine.sv
// Channel   Direction  Handshake             Word
// in_       in         in_valid / in_ready    mme_pkg::in_word_t (command and element)
// out_      out        out_valid / out_ready  mme_pkg::out_word_t (product element)
// cfg       in         psel / penable         APB-style, four 32-bit registers at 4*i
//
// A write word gives no result. A compute word issues one multiply-accumulate
// per cycle while the pipeline is not frozen, rows_first * cols_second *
// cols_first in all, a rate set by the single multiplier and the one read
// port of each store; an element passes from its last read through the store
// read data register and the product register into the output register, and
// the next word is taken once the last read has been issued.
// A dimension mismatch gives a single flagged result word. Reset is synchronous
// and clears the sequencer, the pipeline valid bits, the dimension registers
// and out_valid; the stores are not cleared. A result held back by out_ready
// freezes the read and multiply pipeline when the next is done, until taken.
`default_nettype none

module matrix_multiply_engine #(
  parameter int DIM = mme_pkg::DIM_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire mme_pkg::in_word_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output mme_pkg::out_word_t               out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mme_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [mme_pkg::CFG_DW-1:0]  pwdata,
  output logic      [mme_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int AW = (DIM > 1) ? $clog2(DIM * DIM) : 1;

  // Configuration registers, held as written; the sequencer clamps them.
  mme_pkg::cfg_dims_t dims_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.rows_first  <= 4'd1;
      dims_r.cols_first  <= 4'd1;
      dims_r.rows_second <= 4'd1;
      dims_r.cols_second <= 4'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mme_pkg::REG_ROWS_FIRST:  dims_r.rows_first  <= pwdata[3:0];
        mme_pkg::REG_COLS_FIRST:  dims_r.cols_first  <= pwdata[3:0];
        mme_pkg::REG_ROWS_SECOND: dims_r.rows_second <= pwdata[3:0];
        mme_pkg::REG_COLS_SECOND: dims_r.cols_second <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mme_pkg::REG_ROWS_FIRST:  prdata = 32'(dims_r.rows_first);
      mme_pkg::REG_COLS_FIRST:  prdata = 32'(dims_r.cols_first);
      mme_pkg::REG_ROWS_SECOND: prdata = 32'(dims_r.rows_second);
      mme_pkg::REG_COLS_SECOND: prdata = 32'(dims_r.cols_second);
      default:                  prdata = '0;
    endcase
  end

  // Input decode. Element writes go straight into the stores; writes outside
  // the matrix bounds are dropped.
  logic in_fire, in_range, we_a, we_b, start;
  logic [AW-1:0] waddr;

  assign in_fire  = in_valid && in_ready;
  assign in_range = (32'(in_data.row_index) < DIM) && (32'(in_data.col_index) < DIM);
  assign we_a     = in_fire && in_range && (in_data.opcode == mme_pkg::OP_WR_FIRST);
  assign we_b     = in_fire && in_range && (in_data.opcode == mme_pkg::OP_WR_SECOND);
  assign start    = in_fire && (in_data.opcode == mme_pkg::OP_COMPUTE);
  assign waddr    = AW'(32'(in_data.row_index) * DIM + 32'(in_data.col_index));

  // The pipeline advances unless a finished element meets a full output
  // register that is not being emptied.
  logic adv, seq_idle, re;
  logic [AW-1:0] addr_a, addr_b;
  logic [15:0] rdata_a, rdata_b;
  mme_pkg::mac_tag_t tag;
  logic res_valid;
  mme_pkg::out_word_t res;
  logic out_valid_r, out_valid_nxt, out_load;
  mme_pkg::out_word_t out_data_r;

  assign adv      = !(res_valid && out_valid_r && !out_ready);
  assign in_ready = seq_idle;

  mme_seq #(.DIM(DIM)) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .dims   (dims_r),
    .start  (start),
    .adv    (adv),
    .idle   (seq_idle),
    .re     (re),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .tag    (tag)
  );

  mme_ram #(.WIDTH(16), .DEPTH(DIM * DIM)) u_ram_first (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_data.element_value),
    .re    (re),
    .raddr (addr_a),
    .rdata (rdata_a)
  );

  mme_ram #(.WIDTH(16), .DEPTH(DIM * DIM)) u_ram_second (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_data.element_value),
    .re    (re),
    .raddr (addr_b),
    .rdata (rdata_b)
  );

  mme_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tag_in    (tag),
    .a_data    (rdata_a),
    .b_data    (rdata_b),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: it holds one finished word while the next element is
  // still being accumulated.
  assign out_load      = adv && res_valid;
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A finished element held back by a full output register must not change.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !adv) |=> (res_valid && $stable(res)))
    else $error("finished element lost while output stalled");

  // No new word is taken while the sequencer still issues reads.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !tag.valid)
    else $error("input accepted while reads are being issued");

  // A mismatch result is always the closing word of its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_flag) |-> out_data.last_flag)
    else $error("error word without last marker");
`endif

endmodule

`default_nettype wire

// File: tb/tb_matrix_multiply_engine.sv
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam int EDGE = DIM_DEFAULT;
  // The one opcode value that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles allowed after the last result before the block is taken as idle.
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no word moving on any port before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_WORDS = 140;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  matrix_multiply_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the block: both element stores, a record of which entries have
  // been written since reset, and the four dimension registers as written.
  logic signed [15:0] first_mat [EDGE*EDGE];
  logic signed [15:0] second_mat [EDGE*EDGE];
  bit first_written [EDGE*EDGE];
  bit second_written [EDGE*EDGE];
  cfg_dims_t dims = '{rows_first: 4'd1, cols_first: 4'd1, rows_second: 4'd1,
                      cols_second: 4'd1};

  // Product elements still owed by the block, oldest first.
  out_word_t predicted_products [$];

  int fault_count = 0;
  int words_sent = 0;
  int quiet_cycles = 0;
  // When set, neither side inserts gaps, so words flow back to back.
  bit steady_flow = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // A dimension register is used as 1 when it holds 0 and as EDGE when it
  // holds more than EDGE.
  function automatic int clamp_edge(logic [3:0] value);
    if (value == 4'd0) return 1;
    if (value > EDGE) return EDGE;
    return int'(value);
  endfunction

  // Works out every product element that a compute word gives with the
  // present stores and dimensions. Sums wrap at 32 bits, as the int type does.
  function automatic void predict_product_matrix();
    int m, inner, inner_second, n, acc;
    out_word_t elem;
    m = clamp_edge(dims.rows_first);
    inner = clamp_edge(dims.cols_first);
    inner_second = clamp_edge(dims.rows_second);
    n = clamp_edge(dims.cols_second);
    if (inner != inner_second) begin
      // Mismatched inner dimensions give one flagged word and nothing else.
      elem = '0;
      elem.last_flag = 1'b1;
      elem.error_flag = 1'b1;
      predicted_products.push_back(elem);
      return;
    end
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < inner; k++) begin
          acc += int'(first_mat[i*EDGE+k]) * int'(second_mat[k*EDGE+j]);
        end
        elem.product_value = acc;
        elem.out_row = 3'(i);
        elem.out_col = 3'(j);
        elem.last_flag = (i == m - 1) && (j == n - 1);
        elem.error_flag = 1'b0;
        predicted_products.push_back(elem);
      end
    end
  endfunction

  // Brings the shadow up to date with one accepted command word.
  function automatic void apply_command(in_word_t w);
    case (w.opcode)
      OP_WR_FIRST: begin
        first_mat[{w.row_index, w.col_index}] = w.element_value;
        first_written[{w.row_index, w.col_index}] = 1'b1;
      end
      OP_WR_SECOND: begin
        second_mat[{w.row_index, w.col_index}] = w.element_value;
        second_written[{w.row_index, w.col_index}] = 1'b1;
      end
      OP_COMPUTE: predict_product_matrix();
      default: ;
    endcase
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [2:0] row,
                                         logic [2:0] col, logic [15:0] value);
    in_word_t w;
    w.opcode = op;
    w.row_index = row;
    w.col_index = col;
    w.element_value = value;
    return w;
  endfunction

  // Values lean to the extremes, where products are largest, and to zero and -1.
  function automatic logic [15:0] rand_element();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want_v,
                                        logic [31:0] got_v);
    if (want_v !== got_v) begin
      fault_count++;
      $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name,
               want_v, got_v);
    end
  endfunction

  // Sends one command word. The task is entered at a rising edge and returns
  // at the edge where the word was taken, leaving in_valid high so that a
  // word sent at once afterwards follows with no gap. A caller that does
  // anything else next must lower in_valid in that same step.
  task automatic send_word(in_word_t w);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (w.opcode != OP_UNUSED) words_sent++;
    apply_command(w);
  endtask

  // Stops sending, waits for every owed word and then lets the block settle,
  // since a write word just taken may still be in progress.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (predicted_products.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup phase, then an access phase. The upper bits
  // of the data carry noise, which the register must drop.
  task automatic write_register(logic [1:0] reg_idx, logic [3:0] value);
    logic [31:0] filler;
    filler = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {filler[31:4], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_ROWS_FIRST:  dims.rows_first = value;
      REG_COLS_FIRST:  dims.cols_first = value;
      REG_ROWS_SECOND: dims.rows_second = value;
      REG_COLS_SECOND: dims.cols_second = value;
      default: ;
    endcase
  endtask

  // Registers are only touched once the block has gone idle.
  task automatic set_dims(logic [3:0] rf, logic [3:0] cf, logic [3:0] rs,
                          logic [3:0] cs);
    drain_results();
    write_register(REG_ROWS_FIRST, rf);
    write_register(REG_COLS_FIRST, cf);
    write_register(REG_ROWS_SECOND, rs);
    write_register(REG_COLS_SECOND, cs);
  endtask

  // When inner dimensions match, writes every store entry that the next compute
  // reads and that has never been written, as their contents are not defined.
  task automatic cover_operands();
    int m, inner, n;
    m = clamp_edge(dims.rows_first);
    inner = clamp_edge(dims.cols_first);
    n = clamp_edge(dims.cols_second);
    if (inner != clamp_edge(dims.rows_second)) return;
    for (int i = 0; i < m; i++) begin
      for (int k = 0; k < inner; k++) begin
        if (!first_written[i*EDGE+k])
          send_word(make_word(OP_WR_FIRST, 3'(i), 3'(k), rand_element()));
      end
    end
    for (int k = 0; k < inner; k++) begin
      for (int j = 0; j < n; j++) begin
        if (!second_written[k*EDGE+j])
          send_word(make_word(OP_WR_SECOND, 3'(k), 3'(j), rand_element()));
      end
    end
  endtask

  task automatic send_compute();
    send_word(make_word(OP_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom)));
  endtask

  // With the reset dimensions every matrix is a single element. The largest
  // product of two elements, an ignored opcode and a mixed-sign product.
  task automatic test_single_element();
    send_word(make_word(OP_WR_FIRST, 3'd0, 3'd0, 16'h8000));
    send_word(make_word(OP_WR_SECOND, 3'd0, 3'd0, 16'h8000));
    send_compute();
    send_word(make_word(OP_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom)));
    send_compute();
    send_word(make_word(OP_WR_FIRST, 3'd0, 3'd0, 16'h7fff));
    send_word(make_word(OP_WR_SECOND, 3'd0, 3'd0, 16'hffff));
    send_compute();
  endtask

  // A row of eight times a column of eight, all near full scale, so that the
  // sum goes past 32 bits and must wrap. Indexes reach the top row and column.
  task automatic test_wrapping_sum();
    set_dims(4'd1, 4'd8, 4'd8, 4'd1);
    for (int k = 0; k < EDGE; k++) begin
      send_word(make_word(OP_WR_FIRST, 3'd0, 3'(k), 16'h8000));
      send_word(make_word(OP_WR_SECOND, 3'(k), 3'd0,
                          (k == EDGE - 1) ? 16'h7fff : 16'h8000));
    end
    send_compute();
  endtask

  // Columns of the first matrix clamp to eight, which still differs from
  // seven rows of the second, so the compute word gives the error word.
  task automatic test_dim_mismatch();
    set_dims(4'd3, 4'd15, 4'd7, 4'd2);
    send_compute();
  endtask

  // Zero is used as one and values above eight as eight: this is the same
  // one-by-eight by eight-by-one product as before.
  task automatic test_clamped_dims();
    set_dims(4'd0, 4'd12, 4'd8, 4'd0);
    send_compute();
  endtask

  // The largest product, once back to back and once with both sides idling.
  task automatic test_full_size();
    set_dims(4'd8, 4'd8, 4'd8, 4'd8);
    steady_flow = 1'b1;
    cover_operands();
    send_compute();
    drain_results();
    steady_flow = 1'b0;
    send_compute();
  endtask

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      2, 3: return 4'd8;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // Phases of random traffic. Each phase picks new dimensions, mostly small,
  // then a few rounds of element writes with random content followed by a
  // compute word. An ignored opcode is mixed in now and then as noise.
  task automatic test_random_traffic();
    int start_count;
    logic [3:0] rf, cf, rs, cs;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      rf = pick_dim();
      cf = pick_dim();
      cs = pick_dim();
      rs = ($urandom_range(0, 5) == 0) ? pick_dim() : cf;
      set_dims(rf, cf, rs, cs);
      steady_flow = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 9) == 0)
            send_word(make_word(OP_UNUSED, 3'($urandom), 3'($urandom),
                                16'($urandom)));
          else
            send_word(make_word($urandom_range(0, 1) ? OP_WR_SECOND : OP_WR_FIRST,
                                3'($urandom), 3'($urandom), rand_element()));
        end
        cover_operands();
        send_compute();
      end
    end
    steady_flow = 1'b0;
  endtask

  // Result side: for every word a random stall with ready low, then ready
  // high until a word is taken.
  always begin : result_acceptor
    int stall;
    stall = steady_flow ? 0 : $urandom_range(0, 3);
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!out_valid);
  end

  // Every product word taken is checked against the oldest one owed.
  always @(posedge clk) begin : product_checker
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_products.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected product word, expected none, got 'h%0h", $time,
                 out_data);
      end else begin
        want = predicted_products.pop_front();
        compare_field("product_value", want.product_value, out_data.product_value);
        compare_field("out_row", 32'(want.out_row), 32'(out_data.out_row));
        compare_field("out_col", 32'(want.out_col), 32'(out_data.out_col));
        compare_field("last_flag", 32'(want.last_flag), 32'(out_data.last_flag));
        compare_field("error_flag", 32'(want.error_flag), 32'(out_data.error_flag));
      end
    end
  end

  // The run is declared hung when no word moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_single_element();
    test_wrapping_sum();
    test_dim_mismatch();
    test_clamped_dims();
    test_full_size();
    test_random_traffic();
    drain_results();
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/mme_pkg.sv
rtl/core/mme_ram.sv
rtl/core/mme_seq.sv
rtl/core/mme_mac.sv
rtl/core/matrix_multiply_engine.sv
tb/tb_matrix_multiply_engine.sv
